// File: rtl/nta_pkg.sv
// ============================================================================
// nta_pkg: shared types and constants for the number to ASCII formatter
// Request and response payloads, operation codes and character helpers.
// ============================================================================
package nta_pkg;

   localparam int VALUE_W    = 32;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int FRAC_W     = 23;

   localparam logic [1:0] OP_DEC       = 2'd0;
   localparam logic [1:0] OP_HEX_LOWER = 2'd1;
   localparam logic [1:0] OP_HEX_UPPER = 2'd2;
   localparam logic [1:0] OP_FLOAT     = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_N     = 8'h4e;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_LA    = 8'h61;

   localparam logic [2:0] DIGITS_RESET = 3'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   // ASCII for one hex nibble, upper or lower case letters
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UA : CHAR_LA;
      if (nib < 4'd10) begin
         hex_char = CHAR_ZERO + {4'h0, nib};
      end else begin
         hex_char = base + {4'h0, nib} - 8'd10;
      end
   endfunction

   // ASCII for one decimal digit
   function automatic logic [7:0] dec_char(input logic [3:0] d);
      dec_char = CHAR_ZERO + {4'h0, d};
   endfunction

   // Limit the fraction digit count to 1..6
   function automatic logic [2:0] clamp_digits(input logic [2:0] n);
      if (n == 3'd0) begin
         clamp_digits = 3'd1;
      end else if (n == 3'd7) begin
         clamp_digits = 3'd6;
      end else begin
         clamp_digits = n;
      end
   endfunction

endpackage

// File: rtl/nta_bcd.sv
// ============================================================================
// nta_bcd: iterative binary to BCD converter
// Shift-add-3 conversion, one bit per cycle, done pulses after the last bit.
// ============================================================================
module nta_bcd
   import nta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] bin,
   output logic               done,
   output logic [BCD_W-1:0]   bcd
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [BCD_W-1:0]   adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = bin;
         bcd_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// File: rtl/number_to_ascii_formatter_core.sv
// ============================================================================
// number_to_ascii_formatter_core: binary word to ASCII text
// Prints a signed decimal, lower or upper case hex, or an IEEE single as
// integer part, '.', and a set count of truncated fraction digits.
// ============================================================================
// A request is taken when start is high and busy is low; busy then stays high
// until the last character of that number has been sent. Characters leave at most
// one per cycle on rsp_payload, marked by rsp_strobe, most significant first, with
// last set on the final one. The receiver cannot stall: take every strobed
// character in the cycle it appears. Decimal and float requests first pass
// through the 32-step shift-add-3 BCD converter; hex and "INF" go straight to
// the character sequencer. The fraction digit count comes from the csr
// write channel (always ready); write it only while busy is low.
module number_to_ascii_formatter_core
   import nta_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_strobe,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_SIGN = 4'd2;
   localparam logic [3:0] ST_CONV = 4'd3;
   localparam logic [3:0] ST_DEC  = 4'd4;
   localparam logic [3:0] ST_DOT  = 4'd5;
   localparam logic [3:0] ST_FRAC = 4'd6;
   localparam logic [3:0] ST_HEX  = 4'd7;
   localparam logic [3:0] ST_INF  = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [FRAC_W-1:0]  fx_ff, fx_in;
   logic               neg_ff, neg_in;
   logic [BCD_W-1:0]   sr_ff, sr_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               started_ff, started_in;
   logic [2:0]         ndig_ff, ndig_in;
   logic [2:0]         digits_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic               bcd_start;
   logic               bcd_done;
   logic [BCD_W-1:0]   bcd_value;

   // float decode
   logic [7:0]         expo;
   logic [7:0]         e_up;
   logic [7:0]         s_dn;
   logic [23:0]        mant;
   logic [54:0]        wide;
   logic [23:0]        shr;
   logic               f_inf;
   logic [3:0]         nib;
   logic [26:0]        prod;

   nta_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (mag_ff),
      .done  (bcd_done),
      .bcd   (bcd_value)
   );

   // split the IEEE single into integer part and Q0.23 fraction
   always_comb begin
      expo  = val_ff[30:23];
      mant  = {1'b1, val_ff[22:0]};
      e_up  = expo - 8'd127;
      s_dn  = 8'd127 - expo;
      wide  = {31'h0, mant} << e_up[4:0];
      shr   = mant >> s_dn[6:0];
      f_inf = (expo == 8'd255) || (expo >= 8'd158);
   end

   assign nib  = sr_ff[BCD_W-1 -: 4];
   assign prod = ({4'h0, fx_ff} << 3) + ({4'h0, fx_ff} << 1);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      val_in         = val_ff;
      mag_in         = mag_ff;
      fx_in          = fx_ff;
      neg_in         = neg_ff;
      sr_in          = sr_ff;
      cnt_in         = cnt_ff;
      started_in     = started_ff;
      ndig_in        = ndig_ff;
      bcd_start      = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_payload_in = '{character: CHAR_ZERO, last: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_payload.operation;
               val_in   = req_payload.value;
               ndig_in  = clamp_digits(digits_ff);
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            cnt_in     = '0;
            started_in = 1'b0;
            if (op_ff == OP_DEC) begin
               neg_in   = val_ff[31];
               mag_in   = val_ff[31] ? (32'd0 - val_ff) : val_ff;
               state_in = ST_SIGN;
            end else if (op_ff == OP_FLOAT) begin
               neg_in = val_ff[31] && (val_ff[30:0] != 31'd0);
               if (f_inf) begin
                  state_in = ST_INF;
               end else begin
                  if (expo == 8'd0) begin
                     mag_in = '0;
                     fx_in  = '0;
                  end else if (expo >= 8'd127) begin
                     mag_in = wide[54:23];
                     fx_in  = wide[22:0];
                  end else begin
                     mag_in = '0;
                     fx_in  = shr[22:0];
                  end
                  state_in = ST_SIGN;
               end
            end else begin
               sr_in    = {val_ff, 8'h00};
               state_in = ST_HEX;
            end
         end

         ST_SIGN: begin
            // kick the converter and send the minus sign meanwhile
            if (neg_ff) begin
               rsp_strobe_in            = 1'b1;
               rsp_payload_in.character = CHAR_MINUS;
            end
            bcd_start = 1'b1;
            state_in  = ST_CONV;
         end

         ST_CONV: begin
            if (bcd_done) begin
               sr_in    = bcd_value;
               cnt_in   = '0;
               state_in = ST_DEC;
            end
         end

         ST_DEC: begin
            // drop leading zeros, always show the units digit
            if (started_ff || nib != 4'd0 || cnt_ff == 4'd9) begin
               started_in               = 1'b1;
               rsp_strobe_in            = 1'b1;
               rsp_payload_in.character = dec_char(nib);
               rsp_payload_in.last      = (cnt_ff == 4'd9) && (op_ff == OP_DEC);
            end
            sr_in  = {sr_ff[BCD_W-5:0], 4'h0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd9) begin
               state_in = (op_ff == OP_DEC) ? ST_IDLE : ST_DOT;
            end
         end

         ST_DOT: begin
            rsp_strobe_in            = 1'b1;
            rsp_payload_in.character = CHAR_DOT;
            cnt_in                   = '0;
            state_in                 = ST_FRAC;
         end

         ST_FRAC: begin
            // one truncated fraction digit per cycle: times ten, take the carry
            rsp_strobe_in            = 1'b1;
            rsp_payload_in.character = dec_char(prod[26:23]);
            fx_in                    = prod[22:0];
            cnt_in                   = cnt_ff + 4'd1;
            if (cnt_ff == ({1'b0, ndig_ff} - 4'd1)) begin
               rsp_payload_in.last = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         ST_HEX: begin
            if (started_ff || nib != 4'd0 || cnt_ff == 4'd7) begin
               started_in               = 1'b1;
               rsp_strobe_in            = 1'b1;
               rsp_payload_in.character = hex_char(nib, op_ff == OP_HEX_UPPER);
               rsp_payload_in.last      = (cnt_ff == 4'd7);
            end
            sr_in  = {sr_ff[BCD_W-5:0], 4'h0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               state_in = ST_IDLE;
            end
         end

         ST_INF: begin
            rsp_strobe_in = 1'b1;
            cnt_in        = cnt_ff + 4'd1;
            case (cnt_ff)
               4'd0:    rsp_payload_in.character = CHAR_I;
               4'd1:    rsp_payload_in.character = CHAR_N;
               default: begin
                  rsp_payload_in.character = CHAR_F;
                  rsp_payload_in.last      = 1'b1;
                  state_in                 = ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         digits_ff     <= DIGITS_RESET;
         cnt_ff        <= '0;
         started_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
         started_ff    <= started_in;
         if (csr_valid) begin
            digits_ff <= csr_data;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      val_ff         <= val_in;
      mag_ff         <= mag_in;
      fx_ff          <= fx_in;
      neg_ff         <= neg_in;
      sr_ff          <= sr_in;
      ndig_ff        <= ndig_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
